FILE: rtl/core/recursive_gaussian_pass_core_defines.svh
// ----------------------------------------------------------------------------
// recursive_gaussian_pass_core_defines.svh
// Assertion macros for the recursive Gaussian pass core.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_GAUSSIAN_PASS_CORE_DEFINES_SVH
`define RECURSIVE_GAUSSIAN_PASS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define RGP_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RGP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`else

`define RGP_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg)
`define RGP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)

`endif

`endif

FILE: rtl/core/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types and constants of the recursive Gaussian pass core.
// ----------------------------------------------------------------------------
package rgp_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 12;
   localparam int COEF_FRAC_BITS_DEF = 4;
   localparam int COEF_WIDTH         = 8;
   localparam int CSR_INDEX_WIDTH    = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_INPUT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_TAP_ONE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_TAP_TWO   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_TAP_THREE = 2'd3;

   // unity gain with four fraction bits
   localparam logic signed [COEF_WIDTH-1:0] COEF_INPUT_RESET = 8'sd16;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct packed {
      coef_type coef_input;
      coef_type coef_tap_one;
      coef_type coef_tap_two;
      coef_type coef_tap_three;
   } coef_set_type;

   typedef struct packed {
      logic step;       // item leaves the input stage this cycle
      logic row_start;  // that item opens a row
   } step_ctrl_type;

endpackage

FILE: rtl/core/rgp_req_if.sv
// ----------------------------------------------------------------------------
// rgp_req_if
// Pixel input channel: valid/ready with row marker and B, G, R samples.
// ----------------------------------------------------------------------------
interface rgp_req_if
   import rgp_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic                           row_start;
   logic signed [SAMPLE_WIDTH-1:0] blue_in;
   logic signed [SAMPLE_WIDTH-1:0] green_in;
   logic signed [SAMPLE_WIDTH-1:0] red_in;

   modport source (output valid, row_start, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, row_start, blue_in, green_in, red_in, output ready);
endinterface

FILE: rtl/core/rgp_rsp_if.sv
// ----------------------------------------------------------------------------
// rgp_rsp_if
// Filtered pixel output channel: valid/ready with B, G, R samples.
// ----------------------------------------------------------------------------
interface rgp_rsp_if
   import rgp_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] blue_out;
   logic signed [SAMPLE_WIDTH-1:0] green_out;
   logic signed [SAMPLE_WIDTH-1:0] red_out;

   modport source (output valid, blue_out, green_out, red_out, input ready);
   modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

FILE: rtl/core/rgp_channel_filter.sv
// ----------------------------------------------------------------------------
// rgp_channel_filter
// One color channel: three-tap recursive multiply-add, floor shift, clamp.
// ----------------------------------------------------------------------------
module rgp_channel_filter
   import rgp_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  step_ctrl_type                  ctrl,
   input  coef_set_type                   coefs,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0] filtered
);
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 2;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] hist1_ff, hist2_ff, hist3_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap1, tap2, tap3;
   logic signed [PROD_WIDTH-1:0]   prod0, prod1, prod2, prod3;
   logic signed [ACC_WIDTH-1:0]    acc, shifted;
   logic                           overflow;

   // row start: taps take the current sample
   assign tap1 = ctrl.row_start ? sample : hist1_ff;
   assign tap2 = ctrl.row_start ? sample : hist2_ff;
   assign tap3 = ctrl.row_start ? sample : hist3_ff;

   assign prod0 = sample * coefs.coef_input;
   assign prod1 = tap1 * coefs.coef_tap_one;
   assign prod2 = tap2 * coefs.coef_tap_two;
   assign prod3 = tap3 * coefs.coef_tap_three;

   assign acc = ACC_WIDTH'(prod0) + ACC_WIDTH'(prod1)
              + ACC_WIDTH'(prod2) + ACC_WIDTH'(prod3);
   assign shifted = acc >>> COEF_FRAC_BITS;

   // out of range when the bits above the sample sign differ from it
   assign overflow = (shifted[ACC_WIDTH-1:SAMPLE_WIDTH-1] != '0)
                  && (shifted[ACC_WIDTH-1:SAMPLE_WIDTH-1] != '1);

   always_comb begin
      if (overflow) begin
         filtered = shifted[ACC_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         filtered = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist1_ff <= '0;
         hist2_ff <= '0;
         hist3_ff <= '0;
      end else if (ctrl.step) begin
         hist1_ff <= filtered;
         hist2_ff <= tap1;
         hist3_ff <= tap2;
      end
   end
endmodule

FILE: rtl/core/recursive_gaussian_pass_core.sv
// ----------------------------------------------------------------------------
// recursive_gaussian_pass_core
// One directional pass of a third-order recursive Gaussian filter on BGR.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one pixel per beat (row_start, blue/green/red samples);
//    rsp_chan returns one filtered pixel per accepted beat, in order.
//  - Coefficients are written through csr_wr_en/csr_index/csr_wdata while the
//    core is idle; they are signed, four fraction bits by default.
//  - A beat goes from req_chan into the input register, then through the
//    multiply-add into the result register, which drives rsp_chan.
//  - Throughput: one pixel per clock unless rsp_chan stalls. The filter
//    recursion closes through the per-channel history registers in one
//    multiply-add level, so back-to-back pixels use the prior output directly.
//  - Feed order sets causal vs. anticausal; row_start reloads the taps.
//  - Reset (synchronous) empties both stages, zeros the history and loads
//    unity gain with zero feedback.
//  - When rsp_chan stalls, the result stays put and the input register still
//    takes one more beat; req_chan.ready drops only with both stages full.
// ----------------------------------------------------------------------------
`include "recursive_gaussian_pass_core_defines.svh"

module recursive_gaussian_pass_core
   import rgp_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   rgp_req_if.sink                    req_chan,
   rgp_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);
   // coefficient registers
   coef_set_type coef_ff;

   // input stage
   logic                           s0_valid_ff, s0_valid_in;
   logic                           s0_row_start_ff;
   logic signed [SAMPLE_WIDTH-1:0] s0_blue_ff, s0_green_ff, s0_red_ff;

   // result stage
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_blue_ff, rsp_green_ff, rsp_red_ff;

   logic                           advance;    // result stage can take a beat
   logic                           req_ready;
   step_ctrl_type                  ctrl;
   logic signed [SAMPLE_WIDTH-1:0] blue_filt, green_filt, red_filt;

   // --- configuration -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.coef_input     <= COEF_INPUT_RESET;
         coef_ff.coef_tap_one   <= '0;
         coef_ff.coef_tap_two   <= '0;
         coef_ff.coef_tap_three <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_INPUT:     coef_ff.coef_input     <= csr_wdata;
            CSR_COEF_TAP_ONE:   coef_ff.coef_tap_one   <= csr_wdata;
            CSR_COEF_TAP_TWO:   coef_ff.coef_tap_two   <= csr_wdata;
            CSR_COEF_TAP_THREE: coef_ff.coef_tap_three <= csr_wdata;
         endcase
      end
   end

   // --- handshake -----------------------------------------------------------
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready      = !s0_valid_ff || advance;
   assign req_chan.ready = req_ready;

   assign ctrl.step      = s0_valid_ff && advance;
   assign ctrl.row_start = s0_row_start_ff;

   always_comb begin
      s0_valid_in  = req_ready ? req_chan.valid : s0_valid_ff;
      rsp_valid_in = advance ? s0_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register: takes a beat whenever it is free or draining
   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         s0_row_start_ff <= req_chan.row_start;
         s0_blue_ff      <= req_chan.blue_in;
         s0_green_ff     <= req_chan.green_in;
         s0_red_ff       <= req_chan.red_in;
      end
   end

   // --- datapath: one multiply-add level per channel -------------------------
   rgp_channel_filter #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_blue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .coefs    (coef_ff),
      .sample   (s0_blue_ff),
      .filtered (blue_filt)
   );

   rgp_channel_filter #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_green (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .coefs    (coef_ff),
      .sample   (s0_green_ff),
      .filtered (green_filt)
   );

   rgp_channel_filter #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_red (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .coefs    (coef_ff),
      .sample   (s0_red_ff),
      .filtered (red_filt)
   );

   // result register: loads in step with the history update
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         rsp_blue_ff  <= blue_filt;
         rsp_green_ff <= green_filt;
         rsp_red_ff   <= red_filt;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.blue_out  = rsp_blue_ff;
   assign rsp_chan.green_out = rsp_green_ff;
   assign rsp_chan.red_out   = rsp_red_ff;

   // --- assertions ------------------------------------------------------------
   `RGP_ASSERT_NEXT(a_step_fills_result, clock, reset, ctrl.step, rsp_valid_ff, "beat lost between stages")
   `RGP_ASSERT_IMPLY(a_backpressure_only_full, clock, reset, !req_ready, s0_valid_ff && rsp_valid_ff && !rsp_chan.ready, "input stalled with room left")
   `RGP_ASSERT_NEXT(a_coef_input_write, clock, reset, csr_wr_en && (csr_index == CSR_COEF_INPUT), coef_ff.coef_input == $past(csr_wdata), "coefficient write not taken")
   `RGP_ASSERT_NEXT(a_result_from_stage, clock, reset, !s0_valid_ff && advance, !rsp_valid_ff, "result without an input beat")
endmodule
